// ===== hdl/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Types, constants and arithmetic helpers for the 2-2-1 perceptron forward pass.
// ----------------------------------------------------------------------------
package mlp_pkg;

	// fixed-point widths
	localparam int unsigned DataW = 16;  // Q4.12 features and weights
	localparam int unsigned SumW  = 20;  // saturated Q8.12 sums
	localparam int unsigned ActW  = 13;  // Q.12 activations, 0..4096
	localparam int unsigned ProdW = 32;  // one product
	localparam int unsigned AccW  = 34;  // two products plus shifted bias
	localparam int unsigned FracW = 12;
	localparam int unsigned RegW  = 48;  // one packed weight register
	localparam int unsigned IdxW  = 2;

	localparam logic [ActW-1:0] ActOne = 13'd4096;

	// register indexes
	typedef enum logic [IdxW-1:0] {
		REG_HIDDEN0 = 2'd0,
		REG_HIDDEN1 = 2'd1,
		REG_OUTPUT  = 2'd2
	} reg_idx_t;

	typedef logic signed [DataW-1:0] q4_12_t;
	typedef logic signed [SumW-1:0]  sum_t;
	typedef logic [ActW-1:0]         act_t;
	typedef logic signed [ProdW-1:0] prod_t;

	// pick one signed Q4.12 word out of a packed register
	function automatic q4_12_t wsel(input logic [RegW-1:0] w, input int unsigned k);
		return q4_12_t'(w[k*DataW +: DataW]);
	endfunction

	// add two products and the bias, floor to 12 fraction bits, saturate
	function automatic sum_t neuron_sum(input prod_t p0, input prod_t p1, input q4_12_t bias);
		logic signed [AccW-1:0]       acc;
		logic signed [AccW-FracW-1:0] t;
		sum_t                         r;
		acc = AccW'(p0) + AccW'(p1) + AccW'($signed({bias, {FracW{1'b0}}}));
		t   = (AccW-FracW)'(acc >>> FracW);
		if (t > (AccW-FracW)'(524287))
			r = sum_t'(524287);
		else if (t < -(AccW-FracW)'(524288))
			r = sum_t'(-524288);
		else
			r = sum_t'(t);
		return r;
	endfunction

	// piecewise-linear sigmoid on |x|, mirrored for negative x
	function automatic act_t plan_sigmoid(input sum_t x);
		logic [SumW-1:0] a;
		act_t            y;
		a = x[SumW-1] ? SumW'(-x) : SumW'(x);
		if (a >= 20'd20480)
			y = ActOne;
		else if (a >= 20'd9728)
			y = ActW'(a >> 5) + 13'd3456;
		else if (a >= 20'd4096)
			y = ActW'(a >> 3) + 13'd2560;
		else
			y = ActW'(a >> 2) + 13'd2048;
		return x[SumW-1] ? ActOne - y : y;
	endfunction

	// signed weight times unsigned activation
	function automatic prod_t act_mul(input q4_12_t w, input act_t act);
		logic signed [ActW:0] a;
		a = $signed({1'b0, act});
		return ProdW'(w * a);
	endfunction

endpackage

// ===== hdl/mlp_in_if.sv =====
// ----------------------------------------------------------------------------
// mlp_in_if
// Input channel: one word carries the two Q4.12 features.
// ----------------------------------------------------------------------------
interface mlp_in_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  feature0;
	logic signed [15:0]  feature1;

	modport source (output valid, output feature0, output feature1, input ready);
	modport sink   (input valid, input feature0, input feature1, output ready);
endinterface

// ===== hdl/mlp_out_if.sv =====
// ----------------------------------------------------------------------------
// mlp_out_if
// Result channel: one word carries all sums and activations of one sample.
// ----------------------------------------------------------------------------
interface mlp_out_if;
	logic                valid;
	logic                ready;
	logic signed [19:0]  hidden_sum0;
	logic signed [19:0]  hidden_sum1;
	logic [12:0]         hidden_act0;
	logic [12:0]         hidden_act1;
	logic signed [19:0]  out_sum;
	logic [12:0]         out_act;

	modport source (output valid, output hidden_sum0, output hidden_sum1,
		output hidden_act0, output hidden_act1, output out_sum, output out_act,
		input ready);
	modport sink   (input valid, input hidden_sum0, input hidden_sum1,
		input hidden_act0, input hidden_act1, input out_sum, input out_act,
		output ready);
endinterface

// ===== hdl/mlp_forward_pass.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_pass
// Six-stage pipelined forward pass of a 2-2-1 sigmoid perceptron in Q4.12.
// ----------------------------------------------------------------------------
// The block takes one feature word per cycle while the result side is ready
// and returns one result word per feature word, in order.
// Stages: hidden products, hidden sums, hidden sigmoid, output products,
// output sum, output sigmoid; each stage holds one multiply row or one
// add-and-saturate row or one sigmoid row. Each stage advances on its own, so a stall
// on the result side fills bubbles before it holds the input. Weights are
// written through wr_en/wr_index/wr_data (bits [15:0] first weight, [31:16]
// second weight, [47:32] bias) only while the pipeline is empty; the user
// must ensure this, the block does not enforce it. Index 3 is ignored.
module mlp_forward_pass (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [mlp_pkg::IdxW-1:0]     wr_index,
	input  logic [mlp_pkg::RegW-1:0]     wr_data,
	mlp_in_if.sink                       din,
	mlp_out_if.source                    dout
);
	import mlp_pkg::*;

	logic [RegW-1:0] w_h0_q, w_h1_q, w_o_q;

	// stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;

	prod_t p00_s1, p01_s1, p10_s1, p11_s1;
	sum_t  hsum0_s2, hsum1_s2;
	sum_t  hsum0_s3, hsum1_s3;
	act_t  hact0_s3, hact1_s3;
	sum_t  hsum0_s4, hsum1_s4;
	act_t  hact0_s4, hact1_s4;
	prod_t po0_s4, po1_s4;
	sum_t  hsum0_s5, hsum1_s5;
	act_t  hact0_s5, hact1_s5;
	sum_t  osum_s5;
	sum_t  hsum0_s6, hsum1_s6;
	act_t  hact0_s6, hact1_s6;
	sum_t  osum_s6;
	act_t  oact_s6;

	// write weight registers, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_h0_q <= '0;
			w_h1_q <= '0;
			w_o_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_HIDDEN0: w_h0_q <= wr_data;
				REG_HIDDEN1: w_h1_q <= wr_data;
				REG_OUTPUT:  w_o_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor moves
	assign en6 = !vld_s6 || dout.ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign din.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= din.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: hidden products
	always_ff @(posedge clk) begin
		if (en1) begin
			p00_s1 <= ProdW'(wsel(w_h0_q, 0) * din.feature0);
			p01_s1 <= ProdW'(wsel(w_h0_q, 1) * din.feature1);
			p10_s1 <= ProdW'(wsel(w_h1_q, 0) * din.feature0);
			p11_s1 <= ProdW'(wsel(w_h1_q, 1) * din.feature1);
		end
	end

	// stage 2: hidden sums with bias, floor and saturate
	always_ff @(posedge clk) begin
		if (en2) begin
			hsum0_s2 <= neuron_sum(p00_s1, p01_s1, wsel(w_h0_q, 2));
			hsum1_s2 <= neuron_sum(p10_s1, p11_s1, wsel(w_h1_q, 2));
		end
	end

	// stage 3: hidden activations
	always_ff @(posedge clk) begin
		if (en3) begin
			hsum0_s3 <= hsum0_s2;
			hsum1_s3 <= hsum1_s2;
			hact0_s3 <= plan_sigmoid(hsum0_s2);
			hact1_s3 <= plan_sigmoid(hsum1_s2);
		end
	end

	// stage 4: output products
	always_ff @(posedge clk) begin
		if (en4) begin
			hsum0_s4 <= hsum0_s3;
			hsum1_s4 <= hsum1_s3;
			hact0_s4 <= hact0_s3;
			hact1_s4 <= hact1_s3;
			po0_s4   <= act_mul(wsel(w_o_q, 0), hact0_s3);
			po1_s4   <= act_mul(wsel(w_o_q, 1), hact1_s3);
		end
	end

	// stage 5: output sum
	always_ff @(posedge clk) begin
		if (en5) begin
			hsum0_s5 <= hsum0_s4;
			hsum1_s5 <= hsum1_s4;
			hact0_s5 <= hact0_s4;
			hact1_s5 <= hact1_s4;
			osum_s5  <= neuron_sum(po0_s4, po1_s4, wsel(w_o_q, 2));
		end
	end

	// stage 6: output activation, hold until taken
	always_ff @(posedge clk) begin
		if (en6) begin
			hsum0_s6 <= hsum0_s5;
			hsum1_s6 <= hsum1_s5;
			hact0_s6 <= hact0_s5;
			hact1_s6 <= hact1_s5;
			osum_s6  <= osum_s5;
			oact_s6  <= plan_sigmoid(osum_s5);
		end
	end

	assign dout.valid       = vld_s6;
	assign dout.hidden_sum0 = hsum0_s6;
	assign dout.hidden_sum1 = hsum1_s6;
	assign dout.hidden_act0 = hact0_s6;
	assign dout.hidden_act1 = hact1_s6;
	assign dout.out_sum     = osum_s6;
	assign dout.out_act     = oact_s6;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2-2-1 sigmoid perceptron forward pass.
// ----------------------------------------------------------------------------
// A small tracker class predicts each result word from the feature word that
// was taken and its own copy of the three weight registers, and compares the
// result side field by field in order. Stimulus starts with a directed set
// (reset weights, identity weights across every sigmoid segment, extreme
// weights that saturate the sums) and goes on with random weight settings,
// random gaps on both channels, one long result-side hold and one phase with
// no idling. Weights are only rewritten once the pipeline has drained.
module tb_top;
	import mlp_pkg::*;

	localparam int unsigned  ClkHalf     = 5;
	localparam int unsigned  ResetCycles = 12;
	localparam int unsigned  DrainCycles = 12;   // six pipeline stages plus margin
	localparam int unsigned  HoldCycles  = 300;  // long result-side hold
	localparam int unsigned  CycleLimit  = 400000;
	localparam int unsigned  RandPhases  = 8;
	localparam int unsigned  PhaseItems  = 116;
	localparam int unsigned  MaxReports  = 10;
	localparam logic [IdxW-1:0] RegUnused = 2'd3;

	localparam q4_12_t QOne    = 16'sh1000;
	localparam q4_12_t QNegOne = -16'sh1000;
	localparam q4_12_t QZero   = 16'sh0000;
	localparam q4_12_t QMax    = 16'sh7fff;
	localparam q4_12_t QMin    = 16'sh8000;
	localparam q4_12_t QLsbNeg = 16'shffff;

	typedef struct packed {
		sum_t hsum0;
		sum_t hsum1;
		act_t hact0;
		act_t hact1;
		sum_t osum;
		act_t oact;
	} sample_result_t;

	// predicts result words from features and tracks the ones still in flight
	class sample_tracker;
		logic [RegW-1:0] weight_reg[3];
		sample_result_t  pending_results[$];
		int unsigned     samples_in;
		int unsigned     results_seen;
		int unsigned     mismatches;

		function new();
			foreach (weight_reg[k])
				weight_reg[k] = '0;
			samples_in   = 0;
			results_seen = 0;
			mismatches   = 0;
		endfunction

		// a write to the unused index is dropped
		function void apply_write(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
			if (idx <= REG_OUTPUT)
				weight_reg[idx] = val;
		endfunction

		// weighted sum at 24 fraction bits, floored to 12, clamped to 20 bits
		function sum_t weigh(logic [RegW-1:0] w, longint p, longint q);
			longint acc;
			longint t;
			acc = longint'($signed(w[15:0])) * p + longint'($signed(w[31:16])) * q
				+ longint'($signed(w[47:32])) * 4096;
			t = acc >>> 12;
			if (t > 524287)
				t = 524287;
			else if (t < -524288)
				t = -524288;
			return sum_t'(t);
		endfunction

		// piecewise-linear sigmoid on the magnitude, mirrored for negatives
		function act_t squash(sum_t x);
			longint a;
			longint y;
			a = (x < 0) ? -longint'(x) : longint'(x);
			if (a >= 20480)
				y = 4096;
			else if (a >= 9728)
				y = (a >> 5) + 3456;
			else if (a >= 4096)
				y = (a >> 3) + 2560;
			else
				y = (a >> 2) + 2048;
			if (x < 0)
				y = 4096 - y;
			return act_t'(y);
		endfunction

		function void note_sample(q4_12_t f0, q4_12_t f1);
			sample_result_t r;
			r.hsum0 = weigh(weight_reg[REG_HIDDEN0], longint'(f0), longint'(f1));
			r.hsum1 = weigh(weight_reg[REG_HIDDEN1], longint'(f0), longint'(f1));
			r.hact0 = squash(r.hsum0);
			r.hact1 = squash(r.hsum1);
			r.osum  = weigh(weight_reg[REG_OUTPUT], longint'(r.hact0), longint'(r.hact1));
			r.oact  = squash(r.osum);
			pending_results.push_back(r);
			samples_in++;
		endfunction

		function void check_result(sample_result_t got);
			sample_result_t exp_r;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("%0t: result word with nothing outstanding", $time);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= MaxReports) begin
					$display("%0t: result %0d mismatch", $time, results_seen);
					$display("  expected hs0=%0d hs1=%0d ha0=%0d ha1=%0d os=%0d oa=%0d",
						exp_r.hsum0, exp_r.hsum1, exp_r.hact0, exp_r.hact1,
						exp_r.osum, exp_r.oact);
					$display("  actual   hs0=%0d hs1=%0d ha0=%0d ha1=%0d os=%0d oa=%0d",
						got.hsum0, got.hsum1, got.hact0, got.hact1, got.osum, got.oact);
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            wr_en;
	logic [IdxW-1:0] wr_index;
	logic [RegW-1:0] wr_data;

	mlp_in_if  din_ch ();
	mlp_out_if dout_ch ();

	sample_tracker tracker;
	int unsigned   cycle_count;
	int unsigned   settings_used;
	bit            steady_send;
	bit            steady_take;
	bit            hold_req;

	mlp_forward_pass i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.din      (din_ch.sink),
		.dout     (dout_ch.source)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#ClkHalf clk = 1'b1;
		#ClkHalf clk = 1'b0;
	end

	// note every feature word taken by the block
	always @(posedge clk) begin
		if (arst_n && din_ch.valid && din_ch.ready)
			tracker.note_sample(din_ch.feature0, din_ch.feature1);
	end

	// check every result word taken from the block
	always @(posedge clk) begin
		if (arst_n && dout_ch.valid && dout_ch.ready)
			tracker.check_result({dout_ch.hidden_sum0, dout_ch.hidden_sum1,
				dout_ch.hidden_act0, dout_ch.hidden_act1, dout_ch.out_sum,
				dout_ch.out_act});
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// mostly back to back, sometimes a short pause, rarely a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic q4_12_t rand_feature();
		if ($urandom_range(0, 1))
			return q4_12_t'($urandom_range(0, 65535));
		return q4_12_t'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic q4_12_t rand_weight();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return q4_12_t'($urandom_range(0, 65535));
		else if (r < 8)
			return q4_12_t'(int'($urandom_range(0, 16384)) - 8192);
		case ($urandom_range(0, 4))
			0: return QMin;
			1: return QMax;
			2: return QZero;
			3: return QLsbNeg;
			default: return QOne;
		endcase
	endfunction

	function automatic logic [RegW-1:0] pack_weights(q4_12_t w0, q4_12_t w1, q4_12_t bias);
		return {bias, w1, w0};
	endfunction

	// result side: random stalls, a long hold on request, or always ready
	initial begin
		int unsigned n;
		dout_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				dout_ch.ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else if (steady_take) begin
				dout_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				dout_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				n = pick_gap();
				if (n > 0) begin
					dout_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// one register write; the caller lowers the enable after the batch
	task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		tracker.apply_write(idx, val);
	endtask

	task automatic load_weights(logic [RegW-1:0] h0, logic [RegW-1:0] h1,
		logic [RegW-1:0] o, bit poke_unused);
		write_reg(REG_HIDDEN0, h0);
		write_reg(REG_HIDDEN1, h1);
		write_reg(REG_OUTPUT, o);
		if (poke_unused)
			write_reg(RegUnused, RegW'({$urandom, $urandom}));
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// offer one feature word and hold it until taken
	task automatic send_features(q4_12_t f0, q4_12_t f1);
		int unsigned gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid    <= 1'b1;
		din_ch.feature0 <= f0;
		din_ch.feature1 <= f1;
		do
			@(posedge clk);
		while (!din_ch.ready);
	endtask

	// drop valid and wait for the pipeline to empty
	task automatic settle();
		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		int unsigned ph;
		int unsigned k;
		tracker       = new();
		cycle_count   = 0;
		settings_used = 0;
		steady_send   = 1'b0;
		steady_take   = 1'b0;
		hold_req      = 1'b0;
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= '0;
		wr_data         <= '0;
		din_ch.valid    <= 1'b0;
		din_ch.feature0 <= '0;
		din_ch.feature1 <= '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weights: every sum is zero
		send_features(QMax, QMin);
		send_features(QOne, QNegOne);
		settle();

		// identity hidden weights: walk every sigmoid segment edge, both signs
		load_weights(pack_weights(QOne, QZero, QZero), pack_weights(QZero, QOne, QZero),
			pack_weights(QOne, QNegOne, QZero), 1'b0);
		send_features(16'sd20480, -16'sd20480);
		send_features(16'sd20479, -16'sd20479);
		send_features(16'sd9728, -16'sd9728);
		send_features(16'sd9727, -16'sd9727);
		send_features(16'sd4096, -16'sd4096);
		send_features(16'sd4095, -16'sd4095);
		send_features(16'sd0, -16'sd1);
		send_features(16'sd1, 16'sd0);
		send_features(QMax, QMin);
		send_features(QMin, QMax);
		settle();

		// extreme weights: saturate both hidden sums; the unused index is dropped
		load_weights(pack_weights(QMin, QMin, QMin), pack_weights(QMax, QMax, QMax),
			pack_weights(QMax, QMax, QMax), 1'b1);
		send_features(QMin, QMin);
		send_features(QMax, QMax);
		send_features(QMax, QMin);
		send_features(QZero, QZero);
		settle();

		// tiny negative weights: floor rounding of small negative sums
		load_weights(pack_weights(QLsbNeg, QLsbNeg, QLsbNeg),
			pack_weights(QLsbNeg, QMin, QZero),
			pack_weights(QMin, QMin, QMin), 1'b1);
		send_features(QMax, QMax);
		send_features(QMin, 16'sd1);
		settle();

		// random weight settings with random features
		for (ph = 0; ph < RandPhases; ph++) begin
			load_weights(pack_weights(rand_weight(), rand_weight(), rand_weight()),
				pack_weights(rand_weight(), rand_weight(), rand_weight()),
				pack_weights(rand_weight(), rand_weight(), rand_weight()),
				$urandom_range(0, 2) == 0);
			steady_send = (ph == 2 || ph == 5);
			steady_take = (ph == 5);
			// hold the result side long enough to back up the input
			if (ph == 2)
				hold_req = 1'b1;
			for (k = 0; k < PhaseItems; k++)
				send_features(rand_feature(), rand_feature());
			settle();
		end
		steady_send = 1'b0;
		steady_take = 1'b0;

		$display("tb_top: %0d feature words in, %0d result words checked, %0d weight settings",
			tracker.samples_in, tracker.results_seen, settings_used);
		$display("tb_top: %0d mismatches, %0d results still outstanding",
			tracker.mismatches, tracker.outstanding());
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mlp_pkg.sv
hdl/mlp_in_if.sv
hdl/mlp_out_if.sv
hdl/mlp_forward_pass.sv
tb/tb_top.sv
